### hdl/fqmtf_pkg.sv
// ----------------------------------------------------------------------------
// fqmtf_pkg
// Shared codes and constants of the move-to-front queue: item operations,
// result status, and the command set of the storage cells.
// ----------------------------------------------------------------------------
package fqmtf_pkg;

   // field widths fixed by the stream payload
   localparam int FIELD_W = 16;
   localparam int COUNT_W = 5;
   localparam int OP_W    = 2;
   localparam int STAT_W  = 2;

   // defaults for the top level parameters
   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_DATA_WIDTH = 16;

   // operation requested by an input item
   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_MOVE    = 2'd2,
      OP_QUERY   = 2'd3
   } op_type;

   // status reported with each result item
   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   // command broadcast to every cell in the chain
   typedef enum logic [2:0] {
      CELL_HOLD  = 3'd0,
      CELL_SNAP  = 3'd1,   // copy stored value into the read-out stage
      CELL_SHIFT = 3'd2,   // move read-out stage one cell toward the front
      CELL_ENQ   = 3'd3,   // addressed cell takes the data
      CELL_DEQ   = 3'd4,   // every cell takes its right neighbor's value
      CELL_MOVE  = 3'd5    // cells up to the index take the left neighbor's value
   } cell_op_type;

endpackage

### hdl/fifo_queue_move_to_front_top.sv
// ----------------------------------------------------------------------------
// fifo_queue_move_to_front_top
// Bounded ordered queue with enqueue, dequeue, move-to-front and query,
// built as a chain of storage cells with a read-out chain toward the front.
//
//   channel | dir | tdata (low bit up)                     | tuser
//   req_    | in  | value                                  | operation
//   rsp_    | out | front, back, middle, count, is_empty   | status
//
// Steps: an item updates the cells, snaps them into the read-out chain and
// reads out each entry; a move-to-front that searches first shifts the chain
// to a match or the last entry. The chain brings one entry per cycle to cell 0.
// Reset clears the fill count and the handshake state; entries need none.
// A finished result waits in the output register; a new item is accepted
// while it waits, and the next result holds until the register is taken.
// ----------------------------------------------------------------------------
module fifo_queue_move_to_front_top
   import fqmtf_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] value
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [15:0] front_value, [31:16] back_value,
                                    // [47:32] middle_value, [52:48] count,
                                    // [53] is_empty, [55:54] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int VW = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SNAP,
      S_SEARCH,
      S_REPORT,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  search_ff, search_in;
   logic [IW-1:0]         step_ff, step_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   status_type            status_ff, status_in;
   logic [DATA_WIDTH-1:0] mid_ff, mid_in;
   logic [DATA_WIDTH-1:0] back_ff, back_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [55:0]           rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_user_ff, rsp_user_in;

   cell_op_type           cmd_op;
   logic [IW-1:0]         cmd_index;
   logic [DATA_WIDTH-1:0] cmd_data;

   logic [DATA_WIDTH-1:0] value_w [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_w    [CAPACITY];

   logic [DATA_WIDTH-1:0] in_val;
   logic [DATA_WIDTH-1:0] front_w;
   logic [DATA_WIDTH-1:0] rd_front;
   logic [CW-1:0]         last_idx;
   logic [CW-1:0]         half_cnt;
   logic [CW-1:0]         mid_idx;
   logic [CW-1:0]         step_ext;
   logic                  cnt_zero;

   // build the cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w;
      logic [DATA_WIDTH-1:0] right_w;
      logic [DATA_WIDTH-1:0] right_rd_w;

      if (i == 0) begin : g_first
         assign left_w = cmd_data;
      end else begin : g_inner_left
         assign left_w = value_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_w    = value_w[i];
         assign right_rd_w = rd_w[i];
      end else begin : g_inner_right
         assign right_w    = value_w[i+1];
         assign right_rd_w = rd_w[i+1];
      end

      fqmtf_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .INDEX_W    (IW),
         .CELL_INDEX (i)
      ) u_cell (
         .clock       (clock),
         .cmd_op      (cmd_op),
         .cmd_index   (cmd_index),
         .cmd_data    (cmd_data),
         .left_value  (left_w),
         .right_value (right_w),
         .right_rd    (right_rd_w),
         .value_out   (value_w[i]),
         .rd_out      (rd_w[i])
      );
   end

   // derive queue positions from the fill count
   assign in_val   = DATA_WIDTH'(req_tdata[VW-1:0]);
   assign cnt_zero = (cnt_ff == '0);
   assign front_w  = cnt_zero ? '0 : value_w[0];
   assign rd_front = rd_w[0];
   assign last_idx = cnt_ff - 1'b1;
   assign half_cnt = cnt_ff >> 1;
   assign mid_idx  = (half_cnt == '0) ? '0 : half_cnt - 1'b1;
   assign step_ext = CW'(step_ff);

   assign req_tready = (state_ff == S_IDLE);

   // sequence one item through update, search and read-out
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      search_in    = search_ff;
      step_in      = step_ff;
      val_in       = val_ff;
      status_in    = status_ff;
      mid_in       = mid_ff;
      back_in      = back_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      cmd_op       = CELL_HOLD;
      cmd_index    = '0;
      cmd_data     = val_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               val_in    = in_val;
               cmd_data  = in_val;
               status_in = STAT_OK;
               search_in = 1'b0;
               state_in  = S_SNAP;
               case (op_type'(req_tuser))
                  OP_ENQUEUE: begin
                     if (cnt_ff == FULL_COUNT) begin
                        status_in = STAT_FULL;
                     end else begin
                        cmd_op    = CELL_ENQ;
                        cmd_index = cnt_ff[IW-1:0];
                        cnt_in    = cnt_ff + 1'b1;
                     end
                  end
                  OP_DEQUEUE: begin
                     if (cnt_zero) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        cmd_op = CELL_DEQ;
                        cnt_in = cnt_ff - 1'b1;
                     end
                  end
                  OP_MOVE: begin
                     if (in_val == front_w) begin
                        status_in = STAT_OK;
                     end else if (cnt_zero) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        search_in = 1'b1;
                     end
                  end
                  default: begin
                     status_in = STAT_OK;
                  end
               endcase
            end
         end
         S_SNAP: begin
            cmd_op  = CELL_SNAP;
            step_in = '0;
            if (search_ff) begin
               state_in = S_SEARCH;
            end else if (cnt_zero) begin
               mid_in   = '0;
               back_in  = '0;
               state_in = S_DONE;
            end else begin
               state_in = S_REPORT;
            end
         end
         S_SEARCH: begin
            if (rd_front == val_ff) begin
               cmd_op    = CELL_MOVE;
               cmd_index = step_ff;
               status_in = STAT_OK;
               search_in = 1'b0;
               state_in  = S_SNAP;
            end else if (step_ext == last_idx) begin
               status_in = STAT_NOT_FOUND;
               search_in = 1'b0;
               state_in  = S_SNAP;
            end else begin
               cmd_op  = CELL_SHIFT;
               step_in = step_ff + 1'b1;
            end
         end
         S_REPORT: begin
            if (step_ext == mid_idx) begin
               mid_in = rd_front;
            end
            if (step_ext == last_idx) begin
               back_in  = rd_front;
               state_in = S_DONE;
            end else begin
               cmd_op  = CELL_SHIFT;
               step_in = step_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = 56'({cnt_zero,
                                   COUNT_W'(cnt_ff),
                                   FIELD_W'(mid_ff),
                                   FIELD_W'(back_ff),
                                   FIELD_W'(front_w)});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold control state and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         search_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         search_ff    <= search_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff     <= step_in;
      val_ff      <= val_in;
      status_ff   <= status_in;
      mid_ff      <= mid_in;
      back_ff     <= back_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### hdl/fqmtf_cell.sv
// ----------------------------------------------------------------------------
// fqmtf_cell
// One queue position: a stored value and a read-out stage that feeds the
// read-out chain toward the front of the queue.
// ----------------------------------------------------------------------------
module fqmtf_cell
   import fqmtf_pkg::*;
#(
   parameter int DATA_WIDTH = DEF_DATA_WIDTH,
   parameter int INDEX_W    = 4,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  cell_op_type           cmd_op,
   input  logic [INDEX_W-1:0]    cmd_index,
   input  logic [DATA_WIDTH-1:0] cmd_data,
   input  logic [DATA_WIDTH-1:0] left_value,
   input  logic [DATA_WIDTH-1:0] right_value,
   input  logic [DATA_WIDTH-1:0] right_rd,
   output logic [DATA_WIDTH-1:0] value_out,
   output logic [DATA_WIDTH-1:0] rd_out
);

   localparam logic [INDEX_W-1:0] MY_INDEX = INDEX_W'(CELL_INDEX);

   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [DATA_WIDTH-1:0] rd_ff, rd_in;

   // select the next stored value and read-out value
   always_comb begin
      value_in = value_ff;
      rd_in    = rd_ff;
      case (cmd_op)
         CELL_SNAP: begin
            rd_in = value_ff;
         end
         CELL_SHIFT: begin
            rd_in = right_rd;
         end
         CELL_ENQ: begin
            if (cmd_index == MY_INDEX) begin
               value_in = cmd_data;
            end
         end
         CELL_DEQ: begin
            value_in = right_value;
         end
         CELL_MOVE: begin
            if (MY_INDEX <= cmd_index) begin
               value_in = left_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // hold the entry
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rd_ff    <= rd_in;
   end

   assign value_out = value_ff;
   assign rd_out    = rd_ff;

endmodule
